@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the PID controller block.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define PIDAW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The condition must never be seen outside reset.
`define PIDAW_ASSERT_NEVER(lbl, cond, msg) \
  `PIDAW_ASSERT(lbl, !(cond), msg)

`endif

@@ rtl/pidaw_pkg.sv @@
// Package for the PID controller: fixed-point constants, item types,
// sequencer states and arithmetic helper functions. No dependencies.
`timescale 1ns / 1ps

package pidaw_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned ProdWidth = 2 * DataWidth;
  localparam int unsigned MagWidth  = ProdWidth - FracBits;
  localparam int unsigned CntWidth  = $clog2(DataWidth);
  localparam int unsigned AddrWidth = 5;

  typedef logic signed [DataWidth-1:0] q_t;

  localparam q_t QMax = {1'b0, {(DataWidth - 1){1'b1}}};
  localparam q_t QMin = {1'b1, {(DataWidth - 1){1'b0}}};
  localparam logic signed [DataWidth+1:0] WideMax = (DataWidth + 2)'(QMax);
  localparam logic signed [DataWidth+1:0] WideMin = (DataWidth + 2)'(QMin);

  localparam logic ActClear = 1'b1;

  typedef enum logic [2:0] {
    REG_KP_GAIN        = 3'd0,
    REG_KI_GAIN        = 3'd1,
    REG_KD_GAIN        = 3'd2,
    REG_DEFAULT_STEP   = 3'd3,
    REG_OUTPUT_HIGH    = 3'd4,
    REG_OUTPUT_LOW     = 3'd5,
    REG_INTEGRAL_LIMIT = 3'd6,
    REG_TARGET         = 3'd7
  } reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_P,
    S_MUL_E,
    S_EINT,
    S_ACC,
    S_MUL_I,
    S_ITERM,
    S_DIV,
    S_MUL_D,
    S_DTERM,
    S_SUM,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    KIND_COMPUTE,
    KIND_CLEAR,
    KIND_HOLD
  } kind_e;

  typedef struct packed {
    logic action;
    q_t   measured;
    q_t   step_override;
  } in_item_t;

  typedef struct packed {
    q_t   drive;
    q_t   integral_term;
    q_t   derivative_term;
    logic held;
  } out_item_t;

  function automatic q_t sat_wide(input logic signed [DataWidth+1:0] v);
    q_t r;
    if (v > WideMax) begin
      r = QMax;
    end else if (v < WideMin) begin
      r = QMin;
    end else begin
      r = q_t'(v[DataWidth-1:0]);
    end
    return r;
  endfunction

  function automatic logic [DataWidth-1:0] abs_q(input q_t v);
    logic [DataWidth-1:0] u;
    u = unsigned'(v);
    return v[DataWidth-1] ? (DataWidth'(0) - u) : u;
  endfunction

  // Scales a product magnitude back by the fraction bits, rounding toward
  // minus infinity for negative results, and saturates it.
  function automatic q_t mul_fix(input logic [ProdWidth-1:0] prod, input logic neg);
    logic [MagWidth-1:0] m;
    q_t r;
    m = prod[ProdWidth-1:FracBits] + MagWidth'(neg && (|prod[FracBits-1:0]));
    if (m > MagWidth'(QMax)) begin
      r = neg ? QMin : QMax;
    end else if (neg) begin
      r = q_t'(DataWidth'(0) - m[DataWidth-1:0]);
    end else begin
      r = q_t'(m[DataWidth-1:0]);
    end
    return r;
  endfunction

endpackage

@@ rtl/pidaw_if.sv @@
// Valid/ready channel interfaces for the PID controller items.
// Depends on pidaw_pkg for the payload types.
`timescale 1ns / 1ps

interface pidaw_in_if;
  import pidaw_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface pidaw_out_if;
  import pidaw_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/pid_controller_antiwindup_top.sv @@
// Positional PID controller with integral clamp: one shared multiplier and a
// bit-serial divider under a sequencer, plus the APB register file.
// Depends on pidaw_pkg, pidaw_if.sv and assert_macros.svh.
//
//   Channel   Direction  Handshake           Contents
//   in_if     sink       valid/ready         action, measured, step_override
//   out_if    source     valid/ready         drive, integral_term, derivative_term, held
//   APB       slave      psel/penable/pready the eight gain, limit and step registers
//
// A compute item makes four passes through the shared 32x32 multiplier and 32 steps
// of the restoring divider before the next item is accepted.
// A clear item or an item with a zero step goes straight from idle to the final state.
// Reset loads the register defaults and zeroes the controller history at once.
// The result sits in an output register; the sequencer waits in its last state
// only while that register still holds an item that has not been taken.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module pid_controller_antiwindup_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  pidaw_in_if.sink                         in_if,
  pidaw_out_if.source                      out_if,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pidaw_pkg::AddrWidth-1:0]  paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import pidaw_pkg::*;

  state_e state_q, state_d;
  kind_e  kind_q, kind_d;

  q_t                   kp_q, ki_q, kd_q, ohi_q, olo_q, target_q;
  logic [DataWidth-2:0] dstep_q, ilim_q;

  q_t accum_q, accum_d, prev_err_q, prev_err_d, held_out_q, held_out_d;
  q_t last_it_q, last_it_d, last_dt_q, last_dt_d;

  q_t                   err_q, err_d, p_q, p_d, eint_q, eint_d, acc_q, acc_d;
  q_t                   it_q, it_d, dterm_q, dterm_d, raw_q, raw_d;
  logic [DataWidth-2:0] dt_q, dt_d;

  logic [ProdWidth-1:0] prod_q, prod_d;
  logic                 pneg_q, pneg_d;
  q_t                   mul_a, mul_b, fix_res;

  logic [DataWidth-2:0] rem_q, rem_d;
  logic [DataWidth-1:0] quo_q, quo_d;
  logic [CntWidth-1:0]  cnt_q, cnt_d;
  logic                 dneg_q, dneg_d, dovf_q, dovf_d;
  logic [DataWidth:0]   trial;
  logic signed [DataWidth:0] diff;
  logic [DataWidth:0]   diff_mag;
  logic [DataWidth+FracBits:0] num;
  q_t                   dq;

  logic                 out_valid_q, out_valid_d;
  out_item_t            out_q, out_d;

  logic                 in_fire, out_free, cfg_write, ovr_pos, div_last;
  logic [DataWidth-2:0] dt_sel;
  q_t                   lim, neg_lim, acc_sum, drive_c;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q     <= '0;
      ki_q     <= '0;
      kd_q     <= '0;
      dstep_q  <= (DataWidth - 1)'(655);
      ohi_q    <= QMax;
      olo_q    <= QMin;
      ilim_q   <= '1;
      target_q <= '0;
    end else if (cfg_write) begin
      unique case (reg_e'(paddr[AddrWidth-1:2]))
        REG_KP_GAIN:        kp_q     <= q_t'(pwdata);
        REG_KI_GAIN:        ki_q     <= q_t'(pwdata);
        REG_KD_GAIN:        kd_q     <= q_t'(pwdata);
        REG_DEFAULT_STEP:   dstep_q  <= pwdata[DataWidth-2:0];
        REG_OUTPUT_HIGH:    ohi_q    <= q_t'(pwdata);
        REG_OUTPUT_LOW:     olo_q    <= q_t'(pwdata);
        REG_INTEGRAL_LIMIT: ilim_q   <= pwdata[DataWidth-2:0];
        REG_TARGET:         target_q <= q_t'(pwdata);
      endcase
    end
  end

  always_comb begin
    unique case (reg_e'(paddr[AddrWidth-1:2]))
      REG_KP_GAIN:        prdata = kp_q;
      REG_KI_GAIN:        prdata = ki_q;
      REG_KD_GAIN:        prdata = kd_q;
      REG_DEFAULT_STEP:   prdata = {1'b0, dstep_q};
      REG_OUTPUT_HIGH:    prdata = ohi_q;
      REG_OUTPUT_LOW:     prdata = olo_q;
      REG_INTEGRAL_LIMIT: prdata = {1'b0, ilim_q};
      REG_TARGET:         prdata = target_q;
    endcase
  end

  // Handshakes.
  assign in_if.ready    = (state_q == S_IDLE);
  assign in_fire        = in_if.valid && in_if.ready;
  assign out_free       = !out_valid_q || out_if.ready;
  assign out_if.valid   = out_valid_q;
  assign out_if.payload = out_q;

  assign ovr_pos = !in_if.payload.step_override[DataWidth-1]
                   && (|in_if.payload.step_override);
  assign dt_sel  = ovr_pos ? in_if.payload.step_override[DataWidth-2:0] : dstep_q;

  // Shared multiplier: sign-magnitude product, registered.
  always_comb begin
    unique case (state_q)
      S_MUL_P: begin
        mul_a = kp_q;
        mul_b = err_q;
      end
      S_MUL_E: begin
        mul_a = err_q;
        mul_b = q_t'({1'b0, dt_q});
      end
      S_MUL_I: begin
        mul_a = ki_q;
        mul_b = acc_q;
      end
      S_MUL_D: begin
        mul_a = kd_q;
        mul_b = dq;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d  = abs_q(mul_a) * abs_q(mul_b);
  assign pneg_d  = mul_a[DataWidth-1] ^ mul_b[DataWidth-1];
  assign fix_res = mul_fix(prod_q, pneg_q);

  // Divider operands and one restoring step.
  assign diff     = (DataWidth + 1)'(err_q) - (DataWidth + 1)'(prev_err_q);
  assign diff_mag = diff[DataWidth] ? ((DataWidth + 1)'(0) - unsigned'(diff))
                                    : unsigned'(diff);
  assign num      = {diff_mag, FracBits'(0)};
  assign trial    = {1'b0, rem_q, quo_q[DataWidth-1]} - {2'b00, dt_q};
  assign div_last = (cnt_q == CntWidth'(DataWidth - 1));

  always_comb begin
    if (dovf_q) begin
      dq = dneg_q ? QMin : QMax;
    end else if (dneg_q) begin
      dq = q_t'(DataWidth'(0) - quo_q);
    end else begin
      dq = q_t'(quo_q);
    end
  end

  assign lim     = q_t'({1'b0, ilim_q});
  assign neg_lim = q_t'(DataWidth'(0) - unsigned'(lim));
  assign acc_sum = sat_wide((DataWidth + 2)'(accum_q) + (DataWidth + 2)'(eint_q));

  always_comb begin
    priority if (raw_q > ohi_q) begin
      drive_c = ohi_q;
    end else if (raw_q < olo_q) begin
      drive_c = olo_q;
    end else begin
      drive_c = raw_q;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_if.payload.action == ActClear || dt_sel == '0) begin
            state_d = S_DONE;
          end else begin
            state_d = S_MUL_P;
          end
        end
      end
      S_MUL_P: state_d = S_MUL_E;
      S_MUL_E: state_d = S_EINT;
      S_EINT:  state_d = S_ACC;
      S_ACC:   state_d = S_MUL_I;
      S_MUL_I: state_d = S_ITERM;
      S_ITERM: state_d = S_DIV;
      S_DIV: begin
        if (div_last) begin
          state_d = S_MUL_D;
        end
      end
      S_MUL_D: state_d = S_DTERM;
      S_DTERM: state_d = S_SUM;
      S_SUM:   state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    kind_d      = kind_q;
    err_d       = err_q;
    dt_d        = dt_q;
    p_d         = p_q;
    eint_d      = eint_q;
    acc_d       = acc_q;
    it_d        = it_q;
    dterm_d     = dterm_q;
    raw_d       = raw_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    dneg_d      = dneg_q;
    dovf_d      = dovf_q;
    accum_d     = accum_q;
    prev_err_d  = prev_err_q;
    held_out_d  = held_out_q;
    last_it_d   = last_it_q;
    last_dt_d   = last_dt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_if.ready;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          err_d = sat_wide((DataWidth + 2)'(target_q)
                           - (DataWidth + 2)'(in_if.payload.measured));
          dt_d  = dt_sel;
          if (in_if.payload.action == ActClear) begin
            kind_d = KIND_CLEAR;
          end else if (dt_sel == '0) begin
            kind_d = KIND_HOLD;
          end else begin
            kind_d = KIND_COMPUTE;
          end
        end
      end
      S_MUL_E: p_d = fix_res;
      S_EINT:  eint_d = fix_res;
      S_ACC: begin
        priority if (acc_sum > lim) begin
          acc_d = lim;
        end else if (acc_sum < neg_lim) begin
          acc_d = neg_lim;
        end else begin
          acc_d = acc_sum;
        end
      end
      S_MUL_I: begin
        dneg_d = diff[DataWidth];
        dovf_d = (2 * DataWidth - 2)'(num) >= {dt_q, (DataWidth - 1)'(0)};
        rem_d  = (DataWidth - 1)'(num[DataWidth+FracBits:DataWidth]);
        quo_d  = num[DataWidth-1:0];
        cnt_d  = '0;
      end
      S_ITERM: it_d = fix_res;
      S_DIV: begin
        if (!trial[DataWidth]) begin
          rem_d = trial[DataWidth-2:0];
        end else begin
          rem_d = {rem_q[DataWidth-3:0], quo_q[DataWidth-1]};
        end
        quo_d = {quo_q[DataWidth-2:0], !trial[DataWidth]};
        cnt_d = cnt_q + CntWidth'(1);
      end
      S_DTERM: dterm_d = fix_res;
      S_SUM: begin
        raw_d = sat_wide((DataWidth + 2)'(p_q) + (DataWidth + 2)'(it_q)
                         + (DataWidth + 2)'(dterm_q));
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          unique case (kind_q)
            KIND_CLEAR: begin
              out_d      = '0;
              accum_d    = '0;
              prev_err_d = '0;
              held_out_d = '0;
              last_it_d  = '0;
              last_dt_d  = '0;
            end
            KIND_HOLD: begin
              out_d.drive           = held_out_q;
              out_d.integral_term   = last_it_q;
              out_d.derivative_term = last_dt_q;
              out_d.held            = 1'b1;
            end
            KIND_COMPUTE: begin
              out_d.drive           = drive_c;
              out_d.integral_term   = it_q;
              out_d.derivative_term = dterm_q;
              out_d.held            = 1'b0;
              accum_d               = acc_q;
              prev_err_d            = err_q;
              held_out_d            = drive_c;
              last_it_d             = it_q;
              last_dt_d             = dterm_q;
            end
            default: begin
              out_d = '0;
            end
          endcase
        end
      end
      default: begin
        out_d = out_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= KIND_COMPUTE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      accum_q     <= '0;
      prev_err_q  <= '0;
      held_out_q  <= '0;
      last_it_q   <= '0;
      last_dt_q   <= '0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      accum_q     <= accum_d;
      prev_err_q  <= prev_err_d;
      held_out_q  <= held_out_d;
      last_it_q   <= last_it_d;
      last_dt_q   <= last_dt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q   <= err_d;
    dt_q    <= dt_d;
    p_q     <= p_d;
    eint_q  <= eint_d;
    acc_q   <= acc_d;
    it_q    <= it_d;
    dterm_q <= dterm_d;
    raw_q   <= raw_d;
    prod_q  <= prod_d;
    pneg_q  <= pneg_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    dneg_q  <= dneg_d;
    dovf_q  <= dovf_d;
    out_q   <= out_d;
  end

  `PIDAW_ASSERT(a_accept_leaves_idle, in_fire |=> (state_q != S_IDLE),
                "sequencer stayed idle after accepting an item")
  `PIDAW_ASSERT(a_div_to_mul, (state_q == S_DIV && div_last) |=> (state_q == S_MUL_D),
                "divider did not hand over after its last step")
  `PIDAW_ASSERT_NEVER(a_result_source, $rose(out_valid_q) && ($past(state_q) != S_DONE),
                      "result appeared without passing the final state")

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for pid_controller_antiwindup_top: a shadow of the PID law predicts
// every result, and random items run under varied register settings and handshake stalls.
// Depends on pidaw_pkg, pidaw_if.sv and the RTL of pid_controller_antiwindup_top.
`timescale 1ns / 1ps

module tb_top;
  import pidaw_pkg::*;

  localparam longint QHi = 64'sd2147483647;
  localparam longint QLo = -64'sd2147483648;
  localparam logic ActCompute = ~ActClear;

  class pid_shadow;
    longint kp, ki, kd, step, out_hi, out_lo, int_lim, target;
    longint acc, prev_err, held_drive, held_iterm, held_dterm;
    out_item_t pending_drives[$];
    int mismatches, results_seen, items_seen, clears_seen, holds_seen;

    function new();
      kp = 0;
      ki = 0;
      kd = 0;
      step = 655;
      out_hi = QHi;
      out_lo = QLo;
      int_lim = QHi;
      target = 0;
      acc = 0;
      prev_err = 0;
      held_drive = 0;
      held_iterm = 0;
      held_dterm = 0;
      mismatches = 0;
      results_seen = 0;
      items_seen = 0;
      clears_seen = 0;
      holds_seen = 0;
    endfunction

    function void set_reg(reg_e idx, logic [31:0] v);
      case (idx)
        REG_KP_GAIN: kp = longint'(signed'(v));
        REG_KI_GAIN: ki = longint'(signed'(v));
        REG_KD_GAIN: kd = longint'(signed'(v));
        REG_DEFAULT_STEP: step = longint'({1'b0, v[30:0]});
        REG_OUTPUT_HIGH: out_hi = longint'(signed'(v));
        REG_OUTPUT_LOW: out_lo = longint'(signed'(v));
        REG_INTEGRAL_LIMIT: int_lim = longint'({1'b0, v[30:0]});
        REG_TARGET: target = longint'(signed'(v));
        default: ;
      endcase
    endfunction

    function longint clip(longint v);
      if (v > QHi) return QHi;
      if (v < QLo) return QLo;
      return v;
    endfunction

    // Exact product, scaled back by the fraction bits toward minus infinity.
    function longint fix_mul(longint a, longint b);
      logic neg;
      longint unsigned ma, mb, prod, m;
      neg = (a < 0) != (b < 0);
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      prod = ma * mb;
      m = prod >> FracBits;
      if (neg && prod[FracBits-1:0] != 0) m = m + 1;
      if (m > QHi) return neg ? QLo : QHi;
      return neg ? -longint'(m) : longint'(m);
    endfunction

    // Quotient in fixed point, truncated toward zero and saturated.
    function longint fix_div(longint num, longint den);
      logic neg;
      longint unsigned m, d;
      neg = num < 0;
      m = neg ? -num : num;
      d = den;
      if (m / d > (QHi >> FracBits)) return neg ? QLo : QHi;
      m = (m << FracBits) / d;
      return neg ? -longint'(m) : longint'(m);
    endfunction

    function void note_sample(in_item_t it);
      longint dt, err, p, i_term, d_term, sum, drv;
      out_item_t want;
      items_seen++;
      want = '0;
      if (it.action == ActClear) begin
        clears_seen++;
        acc = 0;
        prev_err = 0;
        held_drive = 0;
        held_iterm = 0;
        held_dterm = 0;
      end else begin
        dt = (it.step_override > 0) ? longint'(it.step_override) : step;
        if (dt == 0) begin
          holds_seen++;
          want.drive = held_drive[31:0];
          want.integral_term = held_iterm[31:0];
          want.derivative_term = held_dterm[31:0];
          want.held = 1'b1;
        end else begin
          err = clip(target - longint'(it.measured));
          p = fix_mul(kp, err);
          acc = clip(acc + fix_mul(err, dt));
          if (acc > int_lim) acc = int_lim;
          if (acc < -int_lim) acc = -int_lim;
          i_term = fix_mul(ki, acc);
          d_term = fix_mul(kd, fix_div(err - prev_err, dt));
          sum = clip(p + i_term + d_term);
          drv = (sum > out_hi) ? out_hi : ((sum < out_lo) ? out_lo : sum);
          prev_err = err;
          held_drive = drv;
          held_iterm = i_term;
          held_dterm = d_term;
          want.drive = drv[31:0];
          want.integral_term = i_term[31:0];
          want.derivative_term = d_term[31:0];
        end
      end
      pending_drives.push_back(want);
    endfunction

    function void check_drive(out_item_t got);
      out_item_t want;
      results_seen++;
      if (pending_drives.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Result %0d arrived with none expected: drive %0d held %0b",
                   results_seen, got.drive, got.held);
        end
        return;
      end
      want = pending_drives.pop_front();
      if (got.drive !== want.drive || got.integral_term !== want.integral_term ||
          got.derivative_term !== want.derivative_term || got.held !== want.held) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Result %0d: drive %0d/%0d integral %0d/%0d derivative %0d/%0d held %0b/%0b",
                   results_seen, want.drive, got.drive, want.integral_term, got.integral_term,
                   want.derivative_term, got.derivative_term, want.held, got.held);
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int settings_written = 0;

  pidaw_in_if in_if ();
  pidaw_out_if out_if ();

  pid_shadow book = new();

  pid_controller_antiwindup_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("[pid_controller_antiwindup_top] ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      book.check_drive(out_if.payload);
    end
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic write_reg(reg_e idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    book.set_reg(idx, value);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.payload <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    book.note_sample(it);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (book.pending_drives.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic in_item_t sample_of(logic act, logic [31:0] meas, logic [31:0] ovr);
    in_item_t it;
    it.action = act;
    it.measured = meas;
    it.step_override = ovr;
    return it;
  endfunction

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(15))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom;
      default: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  task automatic load_random_settings();
    logic [31:0] hi, lo, lim, dstep;
    case ($urandom_range(9))
      0: begin
        lo = $urandom_range(32'h0100_0000);
        hi = 32'h0 - $urandom_range(32'h0100_0000, 1);
      end
      1: begin
        hi = 32'h7FFF_FFFF;
        lo = 32'h8000_0000;
      end
      2: begin
        hi = $urandom;
        lo = $urandom;
      end
      default: begin
        hi = $urandom_range(32'h0100_0000, 32'h0001_0000);
        lo = 32'h0 - $urandom_range(32'h0100_0000, 32'h0001_0000);
      end
    endcase
    case ($urandom_range(9))
      0, 1, 2: lim = hi;
      3: lim = 32'h0;
      4: lim = $urandom;
      default: lim = $urandom_range(32'h0100_0000);
    endcase
    case ($urandom_range(9))
      0: dstep = 32'h0;
      1: dstep = $urandom;
      default: dstep = $urandom_range(32'h0002_0000, 1);
    endcase
    write_reg(REG_KP_GAIN, rand_gain());
    write_reg(REG_KI_GAIN, rand_gain());
    write_reg(REG_KD_GAIN, rand_gain());
    write_reg(REG_DEFAULT_STEP, dstep);
    write_reg(REG_OUTPUT_HIGH, hi);
    write_reg(REG_OUTPUT_LOW, lo);
    write_reg(REG_INTEGRAL_LIMIT, lim);
    write_reg(REG_TARGET, ($urandom_range(9) == 0) ? $urandom :
              $urandom_range(32'h0080_0000) - 32'h0040_0000);
    settings_written++;
  endtask

  // Most measurements sit near the setpoint so the loop settles and winds up slowly.
  function automatic in_item_t next_sample();
    in_item_t it;
    it.action = ($urandom_range(19) == 0) ? ActClear : ActCompute;
    case ($urandom_range(9))
      0, 1: it.measured = $urandom;
      2: it.measured = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: it.measured = book.target[31:0] + $urandom_range(32'h0004_0000) - 32'h0002_0000;
    endcase
    case ($urandom_range(19))
      0, 1, 2, 3, 4, 5, 6, 7: it.step_override = 32'h0;
      8, 9: it.step_override = $urandom | 32'h8000_0000;
      17, 18: it.step_override = $urandom;
      19: it.step_override = 32'h1;
      default: it.step_override = $urandom_range(32'h0002_0000, 1);
    endcase
    return it;
  endfunction

  initial begin
    int phase;
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_if.valid <= 1'b0;
    in_if.payload <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(sample_of(ActCompute, 32'hFFFF_0000, 32'h0));
    send_item(sample_of(ActClear, 32'h1234_5678, 32'h0001_0000));
    wait_idle();

    write_reg(REG_KP_GAIN, 32'h0001_0000);
    write_reg(REG_KI_GAIN, 32'h0000_8000);
    write_reg(REG_KD_GAIN, 32'h0000_4000);
    write_reg(REG_DEFAULT_STEP, 32'd655);
    write_reg(REG_OUTPUT_HIGH, 32'h0064_0000);
    write_reg(REG_OUTPUT_LOW, 32'hFF9C_0000);
    write_reg(REG_INTEGRAL_LIMIT, 32'h0032_0000);
    write_reg(REG_TARGET, 32'h000A_0000);
    send_item(sample_of(ActCompute, 32'h0, 32'h0));
    send_item(sample_of(ActCompute, 32'h7FFF_FFFF, 32'h0001_0000));
    send_item(sample_of(ActCompute, 32'h8000_0000, 32'h7FFF_FFFF));
    send_item(sample_of(ActCompute, 32'h000A_0000, 32'h8000_0000));
    send_item(sample_of(ActCompute, 32'h0009_0000, 32'h1));
    send_item(sample_of(ActClear, 32'h0, 32'h0));
    send_item(sample_of(ActCompute, 32'h000B_0000, 32'h0));
    wait_idle();

    // Zero default step, crossed output limits and saturating gains.
    write_reg(REG_KP_GAIN, 32'h7FFF_FFFF);
    write_reg(REG_KI_GAIN, 32'h8000_0000);
    write_reg(REG_KD_GAIN, 32'h7FFF_FFFF);
    write_reg(REG_DEFAULT_STEP, 32'h0);
    write_reg(REG_OUTPUT_HIGH, 32'hFFFF_0000);
    write_reg(REG_OUTPUT_LOW, 32'h0001_0000);
    write_reg(REG_INTEGRAL_LIMIT, 32'h0);
    write_reg(REG_TARGET, 32'h8000_0000);
    send_item(sample_of(ActCompute, 32'h5, 32'h0));
    send_item(sample_of(ActCompute, 32'h0, 32'hFFFF_FFFF));
    send_item(sample_of(ActCompute, 32'h7FFF_FFFF, 32'h0001_0000));
    send_item(sample_of(ActCompute, 32'h0, 32'h1));
    send_item(sample_of(ActCompute, 32'h0, 32'h0));
    send_item(sample_of(ActClear, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(sample_of(ActCompute, 32'h0, 32'h0));
    send_item(sample_of(ActCompute, 32'h8000_0000, 32'h7FFF_FFFF));
    wait_idle();

    write_reg(REG_KP_GAIN, 32'h8000_0000);
    write_reg(REG_KI_GAIN, 32'h7FFF_FFFF);
    write_reg(REG_KD_GAIN, 32'h8000_0000);
    write_reg(REG_DEFAULT_STEP, 32'hFFFF_FFFF);
    write_reg(REG_OUTPUT_HIGH, 32'h7FFF_FFFF);
    write_reg(REG_OUTPUT_LOW, 32'h8000_0000);
    write_reg(REG_INTEGRAL_LIMIT, 32'hFFFF_FFFF);
    write_reg(REG_TARGET, 32'h7FFF_FFFF);
    send_item(sample_of(ActCompute, 32'h8000_0000, 32'h0));
    send_item(sample_of(ActCompute, 32'h7FFF_FFFF, 32'h8000_0000));
    send_item(sample_of(ActCompute, 32'h0, 32'h0001_0000));
    send_item(sample_of(ActClear, 32'h0, 32'h0));
    wait_idle();
    settings_written = 4;

    for (phase = 0; phase < 12; phase++) begin
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 86;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 86;
        end
        default: begin
          send_idle_pct = 30;
          stall_pct = 30;
        end
      endcase
      load_random_settings();
      repeat (70) send_item(next_sample());
      wait_idle();
    end

    repeat (50) @(posedge clk_i);
    $display("Sent %0d items (%0d clears, %0d held steps) under %0d register settings.",
             book.items_seen, book.clears_seen, book.holds_seen, settings_written);
    $display("Checked %0d results, %0d mismatched.", book.results_seen, book.mismatches);
    if (book.mismatches == 0 && book.pending_drives.size() == 0) begin
      $display("[pid_controller_antiwindup_top] OK");
    end else begin
      $display("[pid_controller_antiwindup_top] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/pidaw_pkg.sv
rtl/pidaw_if.sv
rtl/pid_controller_antiwindup_top.sv
bench/tb_top.sv
